/* rtl/core/periodic_laplacian_ratio_core_macros.svh */
// assertion macros shared by the core
`ifndef PERIODIC_LAPLACIAN_RATIO_CORE_MACROS_SVH
`define PERIODIC_LAPLACIAN_RATIO_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define PLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/plr_pkg.sv */
`default_nettype none
package plr_pkg;
  localparam int unsigned SideMax = 16;
  localparam int unsigned CoordW = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned SideW  = 5;
  localparam int unsigned FracW  = 24;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StZero    = 2'd1,
    StSat     = 2'd2,
    StRange   = 2'd3
  } status_e;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpCompute = 1'b1;

  // command handed from front to back
  typedef struct packed {
    logic                  bad;
    logic [CoordW-1:0]     x;
    logic [CoordW-1:0]     y;
    logic [CoordW-1:0]     z;
    logic [CoordW-1:0]     xp;
    logic [CoordW-1:0]     xm;
    logic [CoordW-1:0]     yp;
    logic [CoordW-1:0]     ym;
    logic [CoordW-1:0]     zp;
    logic [CoordW-1:0]     zm;
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/core/plr_front.sv */
`default_nettype none
module plr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,
  input  wire logic              op_i,
  input  wire logic [3:0]        x_i,
  input  wire logic [3:0]        y_i,
  input  wire logic [3:0]        z_i,
  input  wire logic [4:0]        side_i,
  output plr_pkg::cmd_t          cmd_o,
  output logic                   cmd_valid_o
);
  import plr_pkg::*;

  logic [SideW-1:0] s;
  logic [CoordW-1:0] sm1;
  logic bad;
  cmd_t cmd_d, cmd_q;
  logic valid_q;

  always_comb begin
    s = side_i;
    if (s < SideW'(2)) s = SideW'(2);
    if (s > SideW'(SideMax)) s = SideW'(SideMax);
    sm1 = CoordW'(s - SideW'(1));
    bad = ({1'b0, x_i} >= s) || ({1'b0, y_i} >= s) || ({1'b0, z_i} >= s);
    cmd_d.bad = bad;
    cmd_d.x = x_i;
    cmd_d.y = y_i;
    cmd_d.z = z_i;
    cmd_d.xp = (x_i == sm1) ? '0 : x_i + CoordW'(1);
    cmd_d.xm = (x_i == '0) ? sm1 : x_i - CoordW'(1);
    cmd_d.yp = (y_i == sm1) ? '0 : y_i + CoordW'(1);
    cmd_d.ym = (y_i == '0) ? sm1 : y_i - CoordW'(1);
    cmd_d.zp = (z_i == sm1) ? '0 : z_i + CoordW'(1);
    cmd_d.zm = (z_i == '0) ? sm1 : z_i - CoordW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= acc_i && (op_i == OpCompute);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) cmd_q <= cmd_d;
  end

  assign cmd_o = cmd_q;
  assign cmd_valid_o = valid_q;
endmodule
`default_nettype wire

/* rtl/core/plr_div.sv */
`default_nettype none
module plr_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] num_i,
  input  wire logic [63:0]  den_i,
  output logic [63:0]       quot_o,
  output logic              ovf_o,
  output logic              done_o
);
  // restoring division, 2 bits per cycle; quotient limited to 64 bits plus overflow
  logic [127:0] n_q, n_d;
  logic [64:0]  r_q, r_d;
  logic [63:0]  q_q, q_d;
  logic         ovf_q, ovf_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q;
  logic [64:0]  t;
  logic [63:0]  qt;

  always_comb begin
    n_d = n_q; r_d = r_q; q_d = q_q; ovf_d = ovf_q;
    for (int i = 0; i < 2; i++) begin
      t = {r_d[63:0], n_d[127]};
      n_d = {n_d[126:0], 1'b0};
      qt = q_d;
      if (r_d[64] || t >= {1'b0, den_i}) begin
        r_d = t - {1'b0, den_i};
        q_d = {qt[62:0], 1'b1};
      end else begin
        r_d = t;
        q_d = {qt[62:0], 1'b0};
      end
      ovf_d = ovf_d | qt[63];
    end
    cnt_d = cnt_q - 7'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i; r_q <= '0; q_q <= '0; ovf_q <= 1'b0;
    end else if (busy_q) begin
      n_q <= n_d; r_q <= r_d; q_q <= q_d; ovf_q <= ovf_d;
    end
  end

  assign quot_o = q_q;
  assign ovf_o = ovf_q;
endmodule
`default_nettype wire

/* rtl/core/plr_back.sv */
`default_nettype none
module plr_back #(
  parameter int unsigned AddrW = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire logic [AddrW-1:0]  wr_addr_i,
  input  wire logic [63:0]       wr_data_i,
  input  wire logic              cmd_valid_i,
  input  plr_pkg::cmd_t          cmd_i,
  output logic                   cmd_ready_o,
  output logic                   res_valid_o,
  output logic [31:0]            res_re_o,
  output logic [31:0]            res_im_o,
  output logic [1:0]             res_status_o
);
  import plr_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned CW = AddrW / 3;

  typedef enum logic [3:0] {
    SIdle, SRead, SCheck, SMul, SSum, SDivRe, SDivIm, SDone
  } state_e;

  logic [63:0] mem_q [Depth];
  logic [AddrW-1:0] raddr;
  logic [63:0] rdata_q;

  state_e state_q;
  cmd_t cmd_q;
  logic [3:0] rcnt_q;
  logic signed [31:0] cre_q, cim_q;
  logic signed [35:0] sre_q, sim_q;
  logic signed [35:0] nre_q, nim_q;
  logic signed [67:0] p0_q, p1_q, p2_q, p3_q;
  logic [63:0] den_q;
  logic [127:0] num_re_q, num_im_q;
  logic neg_re_q, neg_im_q, sat_q;
  logic [31:0] qre_q;
  logic div_start_q;
  logic [127:0] div_num;
  logic [63:0] div_q;
  logic div_ovf, div_done;

  function automatic logic [AddrW-1:0] mk_addr(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                                logic [CoordW-1:0] z);
    mk_addr = AddrW'({z[CW-1:0], y[CW-1:0], x[CW-1:0]});
  endfunction

  always_comb begin
    unique case (rcnt_q)
      4'd0: raddr = mk_addr(cmd_q.x, cmd_q.y, cmd_q.z);
      4'd1: raddr = mk_addr(cmd_q.xp, cmd_q.y, cmd_q.z);
      4'd2: raddr = mk_addr(cmd_q.xm, cmd_q.y, cmd_q.z);
      4'd3: raddr = mk_addr(cmd_q.x, cmd_q.yp, cmd_q.z);
      4'd4: raddr = mk_addr(cmd_q.x, cmd_q.ym, cmd_q.z);
      4'd5: raddr = mk_addr(cmd_q.x, cmd_q.y, cmd_q.zp);
      default: raddr = mk_addr(cmd_q.x, cmd_q.y, cmd_q.zm);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_addr_i] <= wr_data_i;
    rdata_q <= mem_q[raddr];
  end

  // magnitude of the signed numerator, pre-shifted by the fraction width
  function automatic logic [127:0] mag_sh(logic signed [67:0] v);
    logic [67:0] m;
    m = v[67] ? 68'(-v) : 68'(v);
    mag_sh = {36'd0, m, 24'd0};
  endfunction

  assign div_num = (state_q == SDivRe) ? num_re_q : num_im_q;

  plr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num),
    .den_i   (den_q),
    .quot_o  (div_q),
    .ovf_o   (div_ovf),
    .done_o  (div_done)
  );

  function automatic logic [31:0] sat_res(logic [63:0] q, logic ovf, logic neg,
                                          output logic s);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    s = ovf || (q > lim);
    sat_res = s ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : (neg ? 32'(-q) : q[31:0]);
  endfunction

  logic [31:0] fin;
  logic fin_sat;
  always_comb fin = sat_res(div_q, div_ovf, (state_q == SDivRe) ? neg_re_q : neg_im_q,
                            fin_sat);

  logic signed [35:0] rd_re, rd_im;
  assign rd_re = 36'(signed'(rdata_q[31:0]));
  assign rd_im = 36'(signed'(rdata_q[63:32]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      res_valid_o <= 1'b0;
      div_start_q <= 1'b0;
      rcnt_q <= '0;
    end else begin
      res_valid_o <= 1'b0;
      div_start_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            rcnt_q <= '0;
            if (cmd_i.bad) begin
              res_valid_o <= 1'b1;
              res_re_o <= '0; res_im_o <= '0; res_status_o <= StRange;
            end else begin
              state_q <= SRead;
            end
          end
        end
        SRead: begin
          // rdata is registered, so it follows its address in the next cycle
          rcnt_q <= rcnt_q + 4'd1;
          if (rcnt_q == 4'd1) begin
            cre_q <= rdata_q[31:0]; cim_q <= rdata_q[63:32];
            sre_q <= '0; sim_q <= '0;
          end else if (rcnt_q > 4'd1) begin
            sre_q <= sre_q + rd_re; sim_q <= sim_q + rd_im;
          end
          if (rcnt_q == 4'd7) state_q <= SCheck;
        end
        SCheck: begin
          if (cre_q == 0 && cim_q == 0) begin
            res_valid_o <= 1'b1;
            res_re_o <= '0; res_im_o <= '0; res_status_o <= StZero;
            state_q <= SIdle;
          end else begin
            nre_q <= sre_q - 36'(cre_q) * 36'sd6;
            nim_q <= sim_q - 36'(cim_q) * 36'sd6;
            state_q <= SMul;
          end
        end
        SMul: begin
          p0_q <= 68'(nre_q) * 68'(cre_q);
          p1_q <= 68'(nim_q) * 68'(cim_q);
          p2_q <= 68'(nim_q) * 68'(cre_q);
          p3_q <= 68'(nre_q) * 68'(cim_q);
          den_q <= 64'(68'(cre_q) * 68'(cre_q) + 68'(cim_q) * 68'(cim_q));
          state_q <= SSum;
        end
        SSum: begin
          num_re_q <= mag_sh(p0_q + p1_q);
          neg_re_q <= (p0_q + p1_q) < 0;
          num_im_q <= mag_sh(p2_q - p3_q);
          neg_im_q <= (p2_q - p3_q) < 0;
          div_start_q <= 1'b1;
          state_q <= SDivRe;
        end
        SDivRe: begin
          if (div_done) begin
            qre_q <= fin; sat_q <= fin_sat;
            div_start_q <= 1'b1;
            state_q <= SDivIm;
          end
        end
        SDivIm: begin
          if (div_done && !div_start_q) begin
            res_valid_o <= 1'b1;
            res_re_o <= qre_q; res_im_o <= fin;
            res_status_o <= (sat_q || fin_sat) ? StSat : StOk;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign cmd_ready_o = (state_q == SIdle);
endmodule
`default_nettype wire

/* rtl/core/periodic_laplacian_ratio_core.sv */
// channel   | direction | handshake       | payload
// command   | in        | start_i / busy_o| operation_i, site_*_i, value_*_i
// result    | out       | done_o strobe   | ratio_re_o, ratio_im_o, status_o
// config    | in        | cfg_we_i        | cfg_data_i (side_length)
// a load is written at its accepting edge and leaves busy_o low
// a compute strobes its result after the hand-off, the lattice reads, the SCheck, SMul
// and SSum states and two divisions (start, steps of 2 bits, capture)
// a zero centre strobes from SCheck, out of range from SIdle; busy_o drops in the strobe cycle
// reset is asynchronous active low; the lattice holds no reset value
// the result strobe lasts one cycle and cannot be stalled by the receiver
`default_nettype none
module periodic_laplacian_ratio_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        operation_i,
  input  wire logic [3:0]  site_x_i,
  input  wire logic [3:0]  site_y_i,
  input  wire logic [3:0]  site_z_i,
  input  wire logic [31:0] value_re_i,
  input  wire logic [31:0] value_im_i,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_data_i,
  output logic             done_o,
  output logic [31:0]      ratio_re_o,
  output logic [31:0]      ratio_im_o,
  output logic [1:0]       status_o
);
  import plr_pkg::*;
  `include "periodic_laplacian_ratio_core_macros.svh"

  localparam int unsigned AddrW = 3 * $clog2(SideMax);

  logic [SideW-1:0] side_q;
  logic acc;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  logic bad_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(16);
    end else if (cfg_we_i) begin
      side_q <= cfg_data_i;
    end
  end

  // busy while the back end or the hand-off register holds a compute
  assign busy_o = !cmd_ready || cmd_valid;
  assign acc = start_i && !busy_o;

  plr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .op_i       (operation_i),
    .x_i        (site_x_i),
    .y_i        (site_y_i),
    .z_i        (site_z_i),
    .side_i     (side_q),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid)
  );

  // out-of-range loads are dropped
  always_comb begin
    logic [SideW-1:0] s;
    s = side_q;
    if (s < SideW'(2)) s = SideW'(2);
    if (s > SideW'(SideMax)) s = SideW'(SideMax);
    bad_ld = ({1'b0, site_x_i} >= s) || ({1'b0, site_y_i} >= s) || ({1'b0, site_z_i} >= s);
  end

  plr_back #(.AddrW(AddrW)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (acc && operation_i == OpLoad && !bad_ld),
    .wr_addr_i    (AddrW'({site_z_i, site_y_i, site_x_i})),
    .wr_data_i    ({value_im_i, value_re_i}),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_ready_o  (cmd_ready),
    .res_valid_o  (done_o),
    .res_re_o     (ratio_re_o),
    .res_im_o     (ratio_im_o),
    .res_status_o (status_o)
  );

  `PLR_ASSERT_NEXT(a_cmd_taken, clk_i, rst_ni, acc && operation_i == OpCompute, busy_o)
  `PLR_ASSERT_IMP(a_zero_on_err, clk_i, rst_ni, done_o && status_o != StOk && status_o != StSat,
                  ratio_re_o == '0 && ratio_im_o == '0)
endmodule
`default_nettype wire

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plr_pkg::*;

  localparam int unsigned SITES = 4096;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASE_ITEMS = 90;

  // one predicted result of a compute request
  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    status_e     st;
  } ratio_t;

  // lattice mirror, ratio predictor and store of predicted ratios
  class ratio_board;
    logic [31:0] site_re [SITES];
    logic [31:0] site_im [SITES];
    bit          loaded [SITES];
    int unsigned side;
    ratio_t      ratio_q[$];
    int unsigned errors;

    function new();
      side = 16;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void set_side(logic [4:0] v);
      // out-of-range register values clamp into [2, 16]
      side = (v < 2) ? 2 : (v > 16) ? 16 : v;
    endfunction

    function int unsigned pending();
      return ratio_q.size();
    endfunction

    function int unsigned at(int unsigned x, int unsigned y, int unsigned z);
      return x + 16 * (y + 16 * z);
    endfunction

    function int unsigned up(int unsigned c);
      return (c + 1 == side) ? 0 : c + 1;
    endfunction

    function int unsigned dn(int unsigned c);
      return (c == 0) ? side - 1 : c - 1;
    endfunction

    // true when centre and all six neighbours hold loaded data;
    // otherwise returns one site still missing
    function bit ready(int unsigned x, int unsigned y, int unsigned z,
                       output int unsigned mx, output int unsigned my,
                       output int unsigned mz);
      int unsigned px[7], py[7], pz[7];
      px = '{x, up(x), dn(x), x, x, x, x};
      py = '{y, y, y, up(y), dn(y), y, y};
      pz = '{z, z, z, z, z, up(z), dn(z)};
      mx = x; my = y; mz = z;
      for (int k = 0; k < 7; k++) begin
        if (!loaded[at(px[k], py[k], pz[k])]) begin
          mx = px[k]; my = py[k]; mz = pz[k];
          return 0;
        end
      end
      return 1;
    endfunction

    // truncated, saturated Q8.24 of num / den
    function logic [31:0] to_q824(logic signed [127:0] num, logic [127:0] den,
                                  inout bit sat);
      logic        neg;
      logic [127:0] mag, q, lim;
      neg = num[127];
      mag = neg ? -num : num;
      mag = mag << FracW;
      q = mag / den;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
        sat = 1;
        q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_request(logic op, int unsigned x, int unsigned y,
                               int unsigned z, logic [31:0] vre, logic [31:0] vim);
      bit                 bad, sat;
      ratio_t             r;
      logic signed [127:0] cre, cim, sre, sim, nre, nim, den;
      int unsigned        px[6], py[6], pz[6], a;
      bad = (x >= side) || (y >= side) || (z >= side);
      if (op == OpLoad) begin
        if (!bad) begin
          a = at(x, y, z);
          site_re[a] = vre;
          site_im[a] = vim;
          loaded[a] = 1;
        end
        return;
      end
      r.re = '0;
      r.im = '0;
      if (bad) begin
        r.st = StRange;
        ratio_q.push_back(r);
        return;
      end
      a = at(x, y, z);
      cre = $signed(site_re[a]);
      cim = $signed(site_im[a]);
      if (cre == 0 && cim == 0) begin
        r.st = StZero;
        ratio_q.push_back(r);
        return;
      end
      // six neighbours with periodic wrap; a side of two counts a site twice
      px = '{up(x), dn(x), x, x, x, x};
      py = '{y, y, up(y), dn(y), y, y};
      pz = '{z, z, z, z, up(z), dn(z)};
      sre = 0;
      sim = 0;
      for (int k = 0; k < 6; k++) begin
        a = at(px[k], py[k], pz[k]);
        sre += $signed(site_re[a]);
        sim += $signed(site_im[a]);
      end
      nre = sre - 6 * cre;
      nim = sim - 6 * cim;
      den = cre * cre + cim * cim;
      sat = 0;
      r.re = to_q824(nre * cre + nim * cim, den, sat);
      r.im = to_q824(nim * cre - nre * cim, den, sat);
      r.st = sat ? StSat : StOk;
      ratio_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] re, logic [31:0] im, logic [1:0] st);
      ratio_t e;
      if (ratio_q.size() == 0) begin
        $error("unexpected ratio re=%h im=%h status=%0d", re, im, st);
        errors++;
        return;
      end
      e = ratio_q.pop_front();
      if (re !== e.re) begin
        $error("ratio_re expected %h actual %h", e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $error("ratio_im expected %h actual %h", e.im, im);
        errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic        operation_i = OpLoad;
  logic [3:0]  site_x_i = '0;
  logic [3:0]  site_y_i = '0;
  logic [3:0]  site_z_i = '0;
  logic [31:0] value_re_i = '0;
  logic [31:0] value_im_i = '0;
  logic        cfg_we_i = 0;
  logic [4:0]  cfg_data_i = '0;
  logic        done_o;
  logic [31:0] ratio_re_o;
  logic [31:0] ratio_im_o;
  logic [1:0]  status_o;

  ratio_board  board = new();
  int unsigned cycles = 0;
  // forces back-to-back requests for a whole phase
  bit          no_gaps = 0;

  periodic_laplacian_ratio_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i,
    .site_x_i, .site_y_i, .site_z_i, .value_re_i, .value_im_i,
    .cfg_we_i, .cfg_data_i, .done_o, .ratio_re_o, .ratio_im_o, .status_o
  );

  always #4 clk_i = ~clk_i;

  // result strobe cannot be held off, so every done cycle is one result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result(ratio_re_o, ratio_im_o, status_o);
    end
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // random word with extra weight on zero, tiny values and the extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  // drive one request from a falling edge and hold it until accepted
  task automatic send(logic op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                      logic [31:0] vre, logic [31:0] vim);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1;
    operation_i <= op;
    site_x_i <= x;
    site_y_i <= y;
    site_z_i <= z;
    value_re_i <= vre;
    value_im_i <= vim;
    do @(posedge clk_i); while (busy_o);
    board.note_request(op, x, y, z, vre, vim);
    @(negedge clk_i);
  endtask

  // drain, let a trailing load settle, then write side_length
  task automatic set_side(logic [4:0] v);
    start_i <= 0;
    while (board.pending() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_data_i <= v;
    board.set_side(v);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // coordinate near the wrap corner so neighbourhoods fill up quickly
  function automatic logic [3:0] near_corner();
    return ($urandom_range(0, 3) == 0) ? 4'(board.side - 1)
                                       : 4'($urandom_range(0, 2) % board.side);
  endfunction

  task automatic random_phase(int unsigned n);
    logic [3:0]  x, y, z;
    int unsigned mx, my, mz;
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      case ($urandom_range(0, 9))
        // noise: any coordinates, out of range included; a compute only where
        // it is out of range or its neighbourhood holds data
        0: begin
          x = 4'($urandom());
          y = 4'($urandom());
          z = 4'($urandom());
          if ($urandom_range(0, 1) == 1 &&
              (x >= board.side || y >= board.side || z >= board.side ||
               board.ready(x, y, z, mx, my, mz))) begin
            send(OpCompute, x, y, z, $urandom(), $urandom());
          end else begin
            send(OpLoad, x, y, z, pick_word(), pick_word());
          end
        end
        // loads across the whole active cube
        1, 2, 3: send(OpLoad, 4'($urandom_range(0, board.side - 1)),
                      4'($urandom_range(0, board.side - 1)),
                      4'($urandom_range(0, board.side - 1)), pick_word(), pick_word());
        default: begin
          x = near_corner();
          y = near_corner();
          z = near_corner();
          // compute only where all seven sites hold data, else fill one
          if (board.ready(x, y, z, mx, my, mz)) begin
            send(OpCompute, x, y, z, $urandom(), $urandom());
          end else begin
            send(OpLoad, 4'(mx), 4'(my), 4'(mz), pick_word(), pick_word());
          end
        end
      endcase
    end
  endtask

  initial begin
    logic [4:0] sides[$];
    sides = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd4, 5'd7, 5'd1, 5'd5, 5'd2, 5'd16};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: side of two, whole cube loaded, extremes among the values
    set_side(5'd2);
    send(OpLoad, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(OpLoad, 4'd1, 4'd0, 4'd0, 32'd1, 32'd0);
    send(OpLoad, 4'd0, 4'd1, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(OpLoad, 4'd1, 4'd1, 4'd0, 32'd0, 32'd0);
    send(OpLoad, 4'd0, 4'd0, 4'd1, 32'hFFFF_FFFF, 32'd3);
    send(OpLoad, 4'd1, 4'd0, 4'd1, 32'd1000, 32'hFFFF_FC18);
    send(OpLoad, 4'd0, 4'd1, 4'd1, 32'd5, 32'd7);
    send(OpLoad, 4'd1, 4'd1, 4'd1, 32'h0100_0000, 32'hFF00_0000);
    // out-of-range load is dropped and must not touch the lattice
    send(OpLoad, 4'd15, 4'd0, 4'd0, 32'hDEAD_BEEF, 32'h1234_5678);
    send(OpCompute, 4'd0, 4'd0, 4'd0, '0, '0);
    send(OpCompute, 4'd1, 4'd1, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // tiny centre, huge neighbours: saturation
    send(OpCompute, 4'd1, 4'd0, 4'd0, '0, '0);
    // zero centre, then two more centres and three out-of-range sites
    send(OpCompute, 4'd1, 4'd1, 4'd0, '0, '0);
    send(OpCompute, 4'd0, 4'd1, 4'd1, '0, '0);
    send(OpCompute, 4'd1, 4'd0, 4'd1, '0, '0);
    send(OpCompute, 4'd15, 4'd15, 4'd15, '0, '0);
    send(OpCompute, 4'd0, 4'd2, 4'd0, '0, '0);
    send(OpCompute, 4'd0, 4'd0, 4'd3, '0, '0);

    foreach (sides[i]) begin
      set_side(sides[i]);
      random_phase(PHASE_ITEMS);
    end

    start_i <= 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* periodic_laplacian_ratio_core.f */
+incdir+rtl/core
rtl/core/plr_pkg.sv
rtl/core/plr_front.sv
rtl/core/plr_div.sv
rtl/core/plr_back.sv
rtl/core/periodic_laplacian_ratio_core.sv
tb/testbench.sv
